[rtl/core/fsnf_pkg.sv]
// Shared types, codes and constants of the format string number formatter.
// Used by fsnf_ctrl, fsnf_dpath and format_string_number_formatter_core.
`default_nettype none

package fsnf_pkg;

   // Width of the value as the conversions see it; the argument port stays 32 bits.
   localparam int VALUE_BITS = 32;
   localparam int ARG_BITS   = 32;
   localparam int CHAR_BITS  = 8;

   // Masks that cut the argument to VALUE_BITS and pick its sign bit.
   localparam logic [ARG_BITS-1:0] VALUE_MASK = (VALUE_BITS >= ARG_BITS) ?
      {ARG_BITS{1'b1}} : ARG_BITS'((65'd1 << VALUE_BITS) - 65'd1);
   localparam logic [ARG_BITS-1:0] SIGN_MASK = (VALUE_BITS > ARG_BITS) ?
      {ARG_BITS{1'b0}} : ARG_BITS'(65'd1 << (VALUE_BITS - 1));

   // Digit stack: a masked magnitude never exceeds ARG_BITS, so ten decimal digits.
   localparam int DIG_DEPTH = 10;
   localparam int DCNT_BITS = $clog2(DIG_DEPTH + 1);

   // Divide by ten as multiply by reciprocal, exact for every ARG_BITS value.
   localparam logic [ARG_BITS-1:0] RECIP       = 32'hCCCC_CCCD;
   localparam int                  RECIP_SHIFT = 35;
   localparam int                  PROD_BITS   = 2 * ARG_BITS;

   // Conversion kinds.
   localparam logic [1:0] CONV_NONE = 2'd0;
   localparam logic [1:0] CONV_DEC  = 2'd1;
   localparam logic [1:0] CONV_HEX  = 2'd2;

   // Characters.
   localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_PCT   = 8'h25;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_BITS-1:0] FMT_D    = 8'h64;
   localparam logic [CHAR_BITS-1:0] FMT_U    = 8'h75;
   localparam logic [CHAR_BITS-1:0] FMT_X    = 8'h78;
   localparam logic [CHAR_BITS-1:0] FMT_P    = 8'h70;
   localparam logic [CHAR_BITS-1:0] FMT_C    = 8'h63;

   localparam logic [CHAR_BITS-1:0] HEX_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   function automatic logic [CHAR_BITS-1:0] hex_char(input logic [3:0] d);
      return HEX_DIGITS[d];
   endfunction

   typedef struct packed {
      logic [CHAR_BITS-1:0] fmt_char;
      logic [ARG_BITS-1:0]  arg_value;
   } req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] out_char;
      logic                 last_char;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic decode;
      logic mul;
      logic step;
      logic emit_pre;
      logic emit_digit;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] dec_conv;
      logic [1:0] dec_pre_cnt;
      logic [1:0] conv;
      logic [1:0] pre_cnt;
      logic       quot_zero;
      logic       dig_last;
      logic       out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/core/fsnf_ctrl.sv]
// Sequencing state machine of the formatter: accept, decode, convert, emit.
// Depends on fsnf_pkg for the command and status structs.
`default_nettype none

module fsnf_ctrl (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire fsnf_pkg::dp_status_type  status,
   output fsnf_pkg::dp_cmd_type          cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_PRE    = 3'd4;
   localparam logic [2:0] ST_DIGIT  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (status.dec_conv == fsnf_pkg::CONV_DEC) begin
               state_in = ST_MUL;
            end else if (status.dec_conv == fsnf_pkg::CONV_HEX) begin
               state_in = ST_DIV;
            end else if (status.dec_pre_cnt != 2'd0) begin
               state_in = ST_PRE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.quot_zero) begin
               state_in = (status.pre_cnt != 2'd0) ? ST_PRE : ST_DIGIT;
            end else begin
               state_in = (status.conv == fsnf_pkg::CONV_DEC) ? ST_MUL : ST_DIV;
            end
         end
         ST_PRE: begin
            if (status.out_free) begin
               cmd.emit_pre = 1'b1;
               if (status.pre_cnt == 2'd1) begin
                  state_in = (status.conv != fsnf_pkg::CONV_NONE) ? ST_DIGIT : ST_IDLE;
               end
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.dig_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Prefix emission only runs with prefix characters left.
   a_pre_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PRE |-> status.pre_cnt != 2'd0)
      else $error("prefix state entered with empty prefix");

endmodule

`default_nettype wire

[rtl/core/fsnf_dpath.sv]
// Datapath of the formatter: format decode, digit conversion, digit stack,
// output register. Depends on fsnf_pkg.
`default_nettype none

module fsnf_dpath (
   input  wire                          clock,
   input  wire                          reset,
   input  wire fsnf_pkg::req_type       req_data,
   input  wire fsnf_pkg::dp_cmd_type    cmd,
   output fsnf_pkg::dp_status_type      status,
   input  wire                          rsp_ready,
   output logic                         rsp_valid,
   output fsnf_pkg::rsp_type            rsp_data
);

   localparam int AB = fsnf_pkg::ARG_BITS;
   localparam int CB = fsnf_pkg::CHAR_BITS;
   localparam int DD = fsnf_pkg::DIG_DEPTH;
   localparam int NB = fsnf_pkg::DCNT_BITS;

   // Payload registers.
   logic [CB-1:0]                 fmt_ff, fmt_in;
   logic [AB-1:0]                 arg_ff, arg_in;
   logic [CB-1:0]                 pre0_ff, pre0_in;
   logic [CB-1:0]                 pre1_ff, pre1_in;
   logic [AB-1:0]                 val_ff, val_in;
   logic [fsnf_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic [3:0]                    stk_ff [DD];
   logic [3:0]                    stk_in [DD];
   fsnf_pkg::rsp_type             rsp_ff, rsp_in;

   // Control registers.
   logic                          pend_ff, pend_in;
   logic [1:0]                    conv_ff, conv_in;
   logic [1:0]                    pre_cnt_ff, pre_cnt_in;
   logic [NB-1:0]                 dcnt_ff, dcnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Decode of the captured item.
   logic [AB-1:0] masked, mag;
   logic          neg;
   logic          d_pend;
   logic [1:0]    d_conv, d_pre_cnt;
   logic [CB-1:0] d_pre0, d_pre1;
   logic [AB-1:0] d_val;

   // One conversion step.
   logic [AB-1:0] quot, quot_x10;
   logic [3:0]    digit;
   logic          out_free;

   always_comb begin
      masked    = arg_ff & fsnf_pkg::VALUE_MASK;
      neg       = |(masked & fsnf_pkg::SIGN_MASK);
      mag       = (~masked + AB'(1)) & fsnf_pkg::VALUE_MASK;
      d_pend    = 1'b0;
      d_conv    = fsnf_pkg::CONV_NONE;
      d_pre_cnt = 2'd0;
      d_pre0    = fmt_ff;
      d_pre1    = fmt_ff;
      d_val     = masked;
      if (fmt_ff == fsnf_pkg::CH_NUL) begin
         d_pend = 1'b0;
      end else if (!pend_ff) begin
         if (fmt_ff == fsnf_pkg::CH_PCT) begin
            d_pend = 1'b1;
         end else begin
            d_pre_cnt = 2'd1;
         end
      end else begin
         case (fmt_ff)
            fsnf_pkg::FMT_D: begin
               d_conv = fsnf_pkg::CONV_DEC;
               if (neg) begin
                  d_pre_cnt = 2'd1;
                  d_pre0    = fsnf_pkg::CH_MINUS;
                  d_val     = mag;
               end
            end
            fsnf_pkg::FMT_U: begin
               d_conv = fsnf_pkg::CONV_DEC;
            end
            fsnf_pkg::FMT_X: begin
               d_conv = fsnf_pkg::CONV_HEX;
            end
            fsnf_pkg::FMT_P: begin
               d_conv    = fsnf_pkg::CONV_HEX;
               d_pre_cnt = 2'd2;
               d_pre0    = fsnf_pkg::CH_ZERO;
               d_pre1    = fsnf_pkg::CH_X;
            end
            fsnf_pkg::FMT_C: begin
               d_pre_cnt = 2'd1;
               d_pre0    = masked[CB-1:0];
            end
            fsnf_pkg::CH_PCT: begin
               d_pre_cnt = 2'd1;
            end
            default: begin
               // unknown specifier: percent sign, then the byte itself
               d_pre_cnt = 2'd2;
               d_pre0    = fsnf_pkg::CH_PCT;
            end
         endcase
      end
   end

   always_comb begin
      if (conv_ff == fsnf_pkg::CONV_DEC) begin
         quot     = AB'(prod_ff >> fsnf_pkg::RECIP_SHIFT);
         quot_x10 = (quot << 3) + (quot << 1);
         digit    = 4'(val_ff - quot_x10);
      end else begin
         quot     = val_ff >> 4;
         quot_x10 = '0;
         digit    = val_ff[3:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      fmt_in       = fmt_ff;
      arg_in       = arg_ff;
      pre0_in      = pre0_ff;
      pre1_in      = pre1_ff;
      val_in       = val_ff;
      prod_in      = prod_ff;
      stk_in       = stk_ff;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      conv_in      = conv_ff;
      pre_cnt_in   = pre_cnt_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         fmt_in = req_data.fmt_char;
         arg_in = req_data.arg_value;
      end
      if (cmd.decode) begin
         pend_in    = d_pend;
         conv_in    = d_conv;
         pre_cnt_in = d_pre_cnt;
         pre0_in    = d_pre0;
         pre1_in    = d_pre1;
         val_in     = d_val;
         dcnt_in    = '0;
      end
      if (cmd.mul) begin
         prod_in = fsnf_pkg::PROD_BITS'(val_ff) * fsnf_pkg::PROD_BITS'(fsnf_pkg::RECIP);
      end
      if (cmd.step) begin
         // push the low digit, keep the quotient
         val_in    = quot;
         stk_in[0] = digit;
         for (int i = 1; i < DD; i++) begin
            stk_in[i] = stk_ff[i-1];
         end
         dcnt_in = dcnt_ff + NB'(1);
      end
      if (cmd.emit_pre) begin
         rsp_in.out_char  = pre0_ff;
         rsp_in.last_char = (pre_cnt_ff == 2'd1) && (conv_ff == fsnf_pkg::CONV_NONE);
         rsp_valid_in     = 1'b1;
         pre0_in          = pre1_ff;
         pre_cnt_in       = pre_cnt_ff - 2'd1;
      end
      if (cmd.emit_digit) begin
         rsp_in.out_char  = fsnf_pkg::hex_char(stk_ff[0]);
         rsp_in.last_char = (dcnt_ff == NB'(1));
         rsp_valid_in     = 1'b1;
         for (int i = 0; i < DD - 1; i++) begin
            stk_in[i] = stk_ff[i+1];
         end
         dcnt_in = dcnt_ff - NB'(1);
      end
   end

   always_ff @(posedge clock) begin
      fmt_ff  <= fmt_in;
      arg_ff  <= arg_in;
      pre0_ff <= pre0_in;
      pre1_ff <= pre1_in;
      val_ff  <= val_in;
      prod_ff <= prod_in;
      stk_ff  <= stk_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         conv_ff      <= fsnf_pkg::CONV_NONE;
         pre_cnt_ff   <= 2'd0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         conv_ff      <= conv_in;
         pre_cnt_ff   <= pre_cnt_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status             = '0;
      status.dec_conv    = d_conv;
      status.dec_pre_cnt = d_pre_cnt;
      status.conv        = conv_ff;
      status.pre_cnt     = pre_cnt_ff;
      status.quot_zero   = (quot == '0);
      status.dig_last    = (dcnt_ff == NB'(1));
      status.out_free    = out_free;
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> dcnt_ff != '0)
      else $error("digit popped from empty stack");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> dcnt_ff < NB'(DD))
      else $error("digit stack overflow");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_pre || cmd.emit_digit) |-> out_free)
      else $error("output register overwritten while held");

endmodule

`default_nettype wire

[rtl/core/format_string_number_formatter_core.sv]
// Top level of the printf-style integer conversion formatter.
// Depends on fsnf_pkg, fsnf_ctrl and fsnf_dpath.
//
//   channel   ports                         direction  carries
//   request   req_valid/req_ready/req_data  in         fmt_char, arg_value
//   response  rsp_valid/rsp_ready/rsp_data  out        out_char, last_char
//
// Sequence: accept, decode, then per decimal digit a reciprocal multiply
//   followed by quotient and remainder, or a shift per hex digit, then
//   emission of each character in turn.
// Reset: synchronous, clears the pending percent flag, the sequencer, the
//   conversion kind, the prefix and digit counts and the output valid;
//   payload registers are left as they are.
// Stalls: a held response stops character emission only; the next request
//   is taken while the last character of the previous one still waits.
`default_nettype none

module format_string_number_formatter_core (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire fsnf_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output fsnf_pkg::rsp_type       rsp_data
);

   fsnf_pkg::dp_cmd_type    cmd;
   fsnf_pkg::dp_status_type status;

   // Sequencer: owns the request handshake and steps the datapath.
   fsnf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: captures the transaction, converts, drives the response.
   fsnf_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for format_string_number_formatter_core.
// Depends on fsnf_pkg for the request/response structs and character codes;
// a directed table runs first, then random format streams under stalls.

module testbench;

   localparam int RANDOM_ITEMS = 384;
   localparam int MAX_CHARS    = 11;   // longest output of one transaction
   localparam int SETTLE       = 40;   // cycles to let the core go quiet at the end
   localparam int QUIET_LIMIT  = 500;  // cycles without any transaction before giving up

   // One directed row: a format byte, its argument, and, where typed, the
   // exact text it must produce (right-aligned, leading zero bytes unused).
   typedef struct packed {
      logic [fsnf_pkg::CHAR_BITS-1:0]           fmt;
      logic [fsnf_pkg::ARG_BITS-1:0]            arg;
      bit                                       typed;
      logic [MAX_CHARS*fsnf_pkg::CHAR_BITS-1:0] text;
   } stim_row_type;

   localparam int DIRECTED = 26;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   fsnf_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   fsnf_pkg::rsp_type rsp_data;

   // Predictor state: pending percent flag and the characters of the
   // transaction under prediction.
   bit                             percent_armed;
   logic [fsnf_pkg::CHAR_BITS-1:0] format_text[$];
   fsnf_pkg::rsp_type              expected_chars[$];

   int                error_count = 0;
   int                item_count  = 0;
   int                burst_left  = 0;
   int                quiet_cycles = 0;
   int                stall_age   = 0;
   logic [7:0]        stall_pattern = 8'hFF;
   fsnf_pkg::rsp_type next_char;
   stim_row_type      directed_rows [DIRECTED];

   format_string_number_formatter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Append the unsigned decimal form of v, most significant digit first.
   function automatic void append_decimal(input logic [fsnf_pkg::ARG_BITS-1:0] v);
      logic [fsnf_pkg::CHAR_BITS-1:0] digits[$];
      do begin
         digits.push_front(fsnf_pkg::CH_ZERO + fsnf_pkg::CHAR_BITS'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digits[i]) format_text.push_back(digits[i]);
   endfunction

   // Append uppercase hex with leading zeros dropped; zero still gives one digit.
   function automatic void append_hex(input logic [fsnf_pkg::ARG_BITS-1:0] v);
      bit started = 1'b0;
      for (int pos = 28; pos >= 0; pos -= 4) begin
         if (v[pos +: 4] != 4'h0 || started || pos == 0) begin
            format_text.push_back(fsnf_pkg::HEX_DIGITS[v[pos +: 4]]);
            started = 1'b1;
         end
      end
   endfunction

   // Work out the characters one format byte produces and advance the flag.
   function automatic void predict_format(input logic [fsnf_pkg::CHAR_BITS-1:0] fmt,
                                          input logic [fsnf_pkg::ARG_BITS-1:0]  arg);
      logic [fsnf_pkg::ARG_BITS-1:0] v;
      v = arg & fsnf_pkg::VALUE_MASK;
      format_text.delete();
      if (fmt == fsnf_pkg::CH_NUL) begin
         percent_armed = 1'b0;
      end else if (!percent_armed) begin
         if (fmt == fsnf_pkg::CH_PCT) percent_armed = 1'b1;
         else format_text.push_back(fmt);
      end else begin
         percent_armed = 1'b0;
         case (fmt)
            fsnf_pkg::FMT_D: begin
               if ((v & fsnf_pkg::SIGN_MASK) != 0) begin
                  format_text.push_back(fsnf_pkg::CH_MINUS);
                  v = (~v + 1) & fsnf_pkg::VALUE_MASK;
               end
               append_decimal(v);
            end
            fsnf_pkg::FMT_U: append_decimal(v);
            fsnf_pkg::FMT_X: append_hex(v);
            fsnf_pkg::FMT_P: begin
               format_text.push_back(fsnf_pkg::CH_ZERO);
               format_text.push_back(fsnf_pkg::CH_X);
               append_hex(v);
            end
            fsnf_pkg::FMT_C:  format_text.push_back(v[fsnf_pkg::CHAR_BITS-1:0]);
            fsnf_pkg::CH_PCT: format_text.push_back(fsnf_pkg::CH_PCT);
            default: begin
               format_text.push_back(fsnf_pkg::CH_PCT);
               format_text.push_back(fmt);
            end
         endcase
      end
      while (format_text.size() > MAX_CHARS) void'(format_text.pop_back());
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Queue the expected characters, then offer the transaction in bursts
   // with random gaps and hold it until the core takes it.
   task automatic send_format(input logic [fsnf_pkg::CHAR_BITS-1:0]           fmt,
                              input logic [fsnf_pkg::ARG_BITS-1:0]            arg,
                              input bit                                       typed,
                              input logic [MAX_CHARS*fsnf_pkg::CHAR_BITS-1:0] text);
      int gap;
      int n;
      predict_format(fmt, arg);
      if (typed) begin
         // Use the hand-written text instead of the predictor's output.
         format_text.delete();
         for (int i = MAX_CHARS - 1; i >= 0; i--) begin
            if (text[i*fsnf_pkg::CHAR_BITS +: fsnf_pkg::CHAR_BITS] != fsnf_pkg::CH_NUL)
               format_text.push_back(text[i*fsnf_pkg::CHAR_BITS +: fsnf_pkg::CHAR_BITS]);
         end
      end
      n = format_text.size();
      for (int i = 0; i < n; i++)
         expected_chars.push_back('{out_char: format_text[i], last_char: (i == n - 1)});

      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{fmt_char: fmt, arg_value: arg};
      do @(posedge clock); while (!req_ready);
      item_count++;
   endtask

   // Hold off new requests until every queued character has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   // Mix of arguments: full random, small, boundary values, short magnitudes, sign bit set.
   function automatic logic [fsnf_pkg::ARG_BITS-1:0] random_arg();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 15);
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
         2: return $urandom >> $urandom_range(0, 31);
         3: return $urandom | 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Byte that follows a percent sign: mostly the known conversions.
   function automatic logic [fsnf_pkg::CHAR_BITS-1:0] random_spec();
      case ($urandom_range(0, 7))
         0: return fsnf_pkg::FMT_D;
         1: return fsnf_pkg::FMT_U;
         2: return fsnf_pkg::FMT_X;
         3: return fsnf_pkg::FMT_P;
         4: return fsnf_pkg::FMT_C;
         5: return fsnf_pkg::CH_PCT;
         default: return fsnf_pkg::CHAR_BITS'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $time);
      error_count++;
   endtask

   // Stall on a rotating pattern that is redrawn when its random age runs out;
   // all-ones gives stretches with no stall at all.
   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_age <= $urandom_range(20, 60);
         case ($urandom_range(0, 3))
            0: stall_pattern <= 8'hFF;
            1: stall_pattern <= 8'h01;
            2: stall_pattern <= 8'($urandom) | 8'h0F;
            default: stall_pattern <= 8'($urandom) | 8'h01;
         endcase
      end else begin
         stall_age     <= stall_age - 1;
         stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      end
      rsp_ready <= stall_pattern[0];
   end

   // Compare each accepted character with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch("unexpected character", 32'h0, {rsp_data.out_char,
                            7'h0, rsp_data.last_char});
         end else begin
            next_char = expected_chars.pop_front();
            if (rsp_data.out_char !== next_char.out_char)
               report_mismatch("out_char", next_char.out_char, rsp_data.out_char);
            if (rsp_data.last_char !== next_char.last_char)
               report_mismatch("last_char", next_char.last_char, rsp_data.last_char);
         end
      end
   end

   // Watchdog: give up when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TIMEOUT: no transaction for %0d cycles at %0t", QUIET_LIMIT, $time);
         $display("format_string_number_formatter_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin
      int next_drain;
      int pick;

      // Directed table: typed rows carry text readable at a glance,
      // the rest are left to the predictor.
      directed_rows = '{
         '{"A",              32'h0000_0000, 1'b1, "A"},
         '{8'hFF,            32'hFFFF_FFFF, 1'b0, '0},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::FMT_D,  32'h0000_0000, 1'b1, "0"},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::FMT_D,  32'h8000_0000, 1'b1, "-2147483648"},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::FMT_D,  32'hFFFF_FFFF, 1'b1, "-1"},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::FMT_U,  32'hFFFF_FFFF, 1'b1, "4294967295"},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::FMT_X,  32'hFFFF_FFFF, 1'b1, "FFFFFFFF"},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::FMT_X,  32'h0000_0000, 1'b1, "0"},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::FMT_P,  32'h0000_ABCD, 1'b1, "0xABCD"},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::FMT_C,  32'h1234_5600, 1'b0, '0},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, "%"},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{8'hFF,            32'h0000_0000, 1'b0, '0},
         '{fsnf_pkg::CH_PCT, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::CH_NUL, 32'h0000_0000, 1'b1, '0},
         '{fsnf_pkg::FMT_X,  32'h0000_0000, 1'b1, "x"},
         '{fsnf_pkg::CH_NUL, 32'hFFFF_FFFF, 1'b1, '0}
      };

      // Hold reset at the start, then release it once.
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_format(directed_rows[i].fmt, directed_rows[i].arg,
                     directed_rows[i].typed, directed_rows[i].text);
      wait_drained();

      // Random streams: mostly percent-plus-conversion pairs, some plain
      // bytes, terminators and raw noise. Drain fully every so often.
      next_drain = item_count + $urandom_range(60, 140);
      while (item_count < DIRECTED + RANDOM_ITEMS) begin
         if (item_count >= next_drain) begin
            wait_drained();
            next_drain = item_count + $urandom_range(60, 140);
         end
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            send_format(fsnf_pkg::CH_PCT, random_arg(), 1'b0, '0);
            send_format(random_spec(), random_arg(), 1'b0, '0);
         end else if (pick < 16) begin
            send_format(fsnf_pkg::CHAR_BITS'($urandom_range(1, 255)), random_arg(),
                        1'b0, '0);
         end else if (pick < 18) begin
            send_format(fsnf_pkg::CH_NUL, random_arg(), 1'b0, '0);
         end else begin
            send_format(fsnf_pkg::CHAR_BITS'($urandom), $urandom, 1'b0, '0);
         end
      end

      // Drop valid, let every character come out, then let the core settle.
      wait_drained();
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("format_string_number_formatter_core test passed");
      end else begin
         $display("format_string_number_formatter_core test failed");
      end
      $finish;
   end

endmodule
